// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the LCD writer checks.
// The clock and reset of the including module are clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the module clock, off while reset is asserted.
`define CLN_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("char lcd writer check failed");

// Same-cycle implication.
`define CLN_IMPLY(lbl, ante, cons) `CLN_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define CLN_NEXT(lbl, ante, cons) `CLN_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hw/rtl/cln_pkg.sv =====
`default_nettype none

package cln_pkg;

	// Input action codes
	typedef enum logic [1:0] {
		ACT_INIT   = 2'd0,
		ACT_CMD    = 2'd1,
		ACT_DATA   = 2'd2,
		ACT_CURSOR = 2'd3
	} action_t;

	// Configuration register indexes
	localparam logic CFG_STROBE_HOLD = 1'b0;
	localparam logic CFG_POWER_WAIT  = 1'b1;

	localparam int HOLD_W   = 17;
	localparam int STROBE_W = 10;
	localparam int EXTRA_W  = 14;

	localparam logic [STROBE_W-1:0] STROBE_HOLD_RST = 10'd20;
	localparam logic [HOLD_W-1:0]   POWER_WAIT_RST  = 17'd50000;

	// Microprogram layout: a four-step byte routine, then the init routine
	localparam int INIT_COUNT = 9;
	localparam int BYTE_ENTRY = 0;
	localparam int INIT_ENTRY = 4;
	localparam int ROM_DEPTH  = INIT_ENTRY + 1 + 4 * INIT_COUNT;
	localparam int PC_W       = $clog2(ROM_DEPTH);

	localparam logic [7:0] INIT_CMD [INIT_COUNT] = '{
		8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
	};
	localparam logic [EXTRA_W-1:0] INIT_EXTRA_US [INIT_COUNT] = '{
		14'd5000, 14'd1000, 14'd10000, 14'd10000, 14'd1000,
		14'd1000, 14'd2000, 14'd1000, 14'd0
	};

	localparam logic [7:0] SET_DDRAM = 8'h80;

	// Hold time source for a step
	typedef enum logic {
		HOLD_STROBE = 1'b0,
		HOLD_POWER  = 1'b1
	} hold_sel_t;

	// One control word of the microprogram
	typedef struct packed {
		logic                use_reg;   // nibble from latched byte, else constant
		logic [7:0]          cbyte;
		logic                lo_nib;
		logic                en;
		hold_sel_t           hold;
		logic [EXTRA_W-1:0]  extra_us;
		logic                last;
	} ucode_t;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t            w;
		logic [PC_W-1:0]   off;
		logic [3:0]        idx;
		logic [1:0]        ph;
		w = '0;
		w.hold = HOLD_STROBE;
		off = pc - PC_W'(INIT_ENTRY + 1);
		idx = off[PC_W-1:2];
		ph = off[1:0];
		if (pc < PC_W'(INIT_ENTRY)) begin
			w.use_reg = 1'b1;
			w.lo_nib = pc[1];
			w.en = !pc[0];
			w.last = (pc == PC_W'(INIT_ENTRY - 1));
		end else if (pc == PC_W'(INIT_ENTRY)) begin
			w.hold = HOLD_POWER;
		end else if (pc < PC_W'(ROM_DEPTH)) begin
			w.cbyte = INIT_CMD[idx];
			w.lo_nib = ph[1];
			w.en = !ph[0];
			if (ph == 2'd3) begin
				w.extra_us = INIT_EXTRA_US[idx];
			end
			w.last = (pc == PC_W'(ROM_DEPTH - 1));
		end else begin
			w.last = 1'b1;
		end
		return w;
	endfunction

	// DDRAM row base for rows one to four, zero otherwise
	function automatic logic [7:0] row_base(input logic [2:0] row);
		logic [7:0] b;
		unique case (row)
			3'd1:    b = 8'h00;
			3'd2:    b = 8'h40;
			3'd3:    b = 8'h14;
			3'd4:    b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_writer.sv =====
`default_nettype none
// Character LCD writer for a 4-bit bus.
// Command channel: an item (action, data_byte, row, column) is taken at a
// clock edge where start is high and busy is low. Actions: init sequence,
// command byte, data byte, set cursor (command 0x80 | base+column-1).
// Every pin step comes out as one result on reg_select, nibble, enable,
// hold_us and last, valid for exactly one cycle while result_strobe is high;
// last marks the final step of the item. Results cannot be held off.
// The accepting edge loads the step counter; the result registers then take the first step.
// A byte action gives 4 steps, one per cycle, and the next item is taken
// at the edge that registers the final step, so items can follow back to back.
// The init action gives 37 steps.
// Steps are read from a 41-word microcode ROM by a step counter; one word
// per cycle sets the rate.
// Configuration: cfg_write with cfg_index 0 (strobe hold, us) or
// 1 (power-on wait, us) and cfg_data; write only while idle.
// Reset: asynchronous, clears the sequencer and loads the default register
// values (20 us strobe hold, 50000 us power-on wait).
`include "assert_macros.svh"

module char_lcd_nibble_writer import cln_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        action,
	input  wire logic [7:0]        data_byte,
	input  wire logic [2:0]        row,
	input  wire logic [7:0]        column,
	input  wire logic              cfg_write,
	input  wire logic              cfg_index,
	input  wire logic [HOLD_W-1:0] cfg_data,
	output logic                   result_strobe,
	output logic                   reg_select,
	output logic [3:0]             nibble,
	output logic                   enable,
	output logic [HOLD_W-1:0]      hold_us,
	output logic                   last
);

	logic [STROBE_W-1:0] strobe_hold_q;
	logic [HOLD_W-1:0]   power_wait_q;
	logic                running_q;
	logic [PC_W-1:0]     pc_q;
	logic [7:0]          byte_q;
	logic                rs_q;

	logic                strobe_q;
	logic                rs_out_q;
	logic [3:0]          nib_out_q;
	logic                en_out_q;
	logic [HOLD_W-1:0]   hold_out_q;
	logic                last_out_q;

	ucode_t              uw;
	logic                accept;
	logic [7:0]          cursor_cmd;
	logic [7:0]          src_byte;
	logic [3:0]          step_nib;
	logic [HOLD_W-1:0]   step_hold;

	// Microcode fetch for the current step
	assign uw = ucode_rom(pc_q);

	// Free on the cycle of the final step, so the next item follows directly
	assign busy = running_q && !uw.last;
	assign accept = start && !busy;

	// Cursor command: base + column - 1, wrapped at eight bits
	assign cursor_cmd = SET_DDRAM | (row_base(row) + column + 8'hFF);

	// Step datapath
	always_comb begin
		src_byte = uw.use_reg ? byte_q : uw.cbyte;
		step_nib = uw.lo_nib ? src_byte[3:0] : src_byte[7:4];
		if (uw.hold == HOLD_POWER) begin
			step_hold = power_wait_q;
		end else begin
			step_hold = HOLD_W'(strobe_hold_q) + HOLD_W'(uw.extra_us);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_hold_q <= STROBE_HOLD_RST;
			power_wait_q <= POWER_WAIT_RST;
		end else if (cfg_write) begin
			if (cfg_index == CFG_STROBE_HOLD) begin
				strobe_hold_q <= cfg_data[STROBE_W-1:0];
			end else begin
				power_wait_q <= cfg_data;
			end
		end
	end

	// Sequencer: dispatch on accept, step through the ROM, stop on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pc_q <= '0;
		end else if (accept) begin
			running_q <= 1'b1;
			pc_q <= (action_t'(action) == ACT_INIT) ? PC_W'(INIT_ENTRY) : PC_W'(BYTE_ENTRY);
		end else if (running_q) begin
			running_q <= !uw.last;
			pc_q <= pc_q + 1'b1;
		end
	end

	// Item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (action_t'(action))
				ACT_INIT: begin
					byte_q <= 8'h00;
					rs_q <= 1'b0;
				end
				ACT_CMD: begin
					byte_q <= data_byte;
					rs_q <= 1'b0;
				end
				ACT_DATA: begin
					byte_q <= data_byte;
					rs_q <= 1'b1;
				end
				ACT_CURSOR: begin
					byte_q <= cursor_cmd;
					rs_q <= 1'b0;
				end
				default: begin
					byte_q <= 8'h00;
					rs_q <= 1'b0;
				end
			endcase
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= running_q;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (running_q) begin
			rs_out_q <= uw.use_reg && rs_q;
			nib_out_q <= step_nib;
			en_out_q <= uw.en;
			hold_out_q <= step_hold;
			last_out_q <= uw.last;
		end
	end

	assign result_strobe = strobe_q;
	assign reg_select = rs_out_q;
	assign nibble = nib_out_q;
	assign enable = en_out_q;
	assign hold_us = hold_out_q;
	assign last = last_out_q;

	// Checks
	`CLN_IMPLY(a_pc_range, running_q, pc_q < PC_W'(ROM_DEPTH))
	`CLN_NEXT(a_accept_runs, accept, running_q && result_strobe == $past(running_q))
	`CLN_NEXT(a_enable_pair, result_strobe && enable, result_strobe && !enable && nibble == $past(nibble))
	`CLN_NEXT(a_no_gap, result_strobe && !last, result_strobe)

endmodule

`default_nettype wire

// ===== tb/char_lcd_nibble_writer_tb.sv =====
module char_lcd_nibble_writer_tb;
	import cln_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 25;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DIRECTED_COUNT  = 21;

	// Power-on command bytes and the delay after each, in ms
	localparam logic [7:0] POWER_ON_CMDS [9] = '{
		8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
	};
	localparam int POWER_ON_MS [9] = '{5, 1, 10, 10, 1, 1, 2, 1, 0};

	// One pin step as seen on the result ports
	typedef struct packed {
		logic              rs;
		logic [3:0]        nib;
		logic              en;
		logic [HOLD_W-1:0] hold;
		logic              last;
	} pin_step_t;

	// Directed item; sent is the byte on the pins when typed is set
	typedef struct packed {
		action_t    act;
		logic [7:0] dbyte;
		logic [2:0] row_v;
		logic [7:0] col_v;
		logic       typed;
		logic [7:0] sent;
	} lcd_vec_t;

	localparam lcd_vec_t DIRECTED [DIRECTED_COUNT] = '{
		'{ACT_INIT,   8'h00, 3'd0, 8'h00, 1'b0, 8'h00},
		'{ACT_CMD,    8'h00, 3'd0, 8'h00, 1'b1, 8'h00},
		'{ACT_CMD,    8'hFF, 3'd0, 8'h00, 1'b1, 8'hFF},
		'{ACT_DATA,   8'h00, 3'd0, 8'h00, 1'b1, 8'h00},
		'{ACT_DATA,   8'hFF, 3'd0, 8'h00, 1'b1, 8'hFF},
		'{ACT_DATA,   8'hA5, 3'd0, 8'h00, 1'b0, 8'h00},
		'{ACT_CMD,    8'h5A, 3'd0, 8'h00, 1'b0, 8'h00},
		'{ACT_CURSOR, 8'h00, 3'd1, 8'd1,  1'b1, 8'h80},
		'{ACT_CURSOR, 8'h00, 3'd2, 8'd1,  1'b1, 8'hC0},
		'{ACT_CURSOR, 8'h00, 3'd3, 8'd1,  1'b1, 8'h94},
		'{ACT_CURSOR, 8'h00, 3'd4, 8'd1,  1'b1, 8'hD4},
		'{ACT_CURSOR, 8'h00, 3'd0, 8'd5,  1'b1, 8'h84},
		'{ACT_CURSOR, 8'h00, 3'd5, 8'd1,  1'b1, 8'h80},
		'{ACT_CURSOR, 8'h00, 3'd7, 8'd255, 1'b1, 8'hFE},
		// column zero wraps the address below zero
		'{ACT_CURSOR, 8'h00, 3'd1, 8'd0,  1'b1, 8'hFF},
		// address past 0xFF wraps
		'{ACT_CURSOR, 8'h00, 3'd4, 8'd255, 1'b1, 8'hD2},
		'{ACT_CURSOR, 8'h00, 3'd2, 8'd200, 1'b1, 8'h87},
		'{ACT_CURSOR, 8'h00, 3'd6, 8'd0,  1'b1, 8'hFF},
		// fields that the action ignores carry junk
		'{ACT_CMD,    8'h3C, 3'd7, 8'hAA, 1'b1, 8'h3C},
		'{ACT_CURSOR, 8'hFF, 3'd3, 8'd10, 1'b1, 8'h9D},
		'{ACT_INIT,   8'hFF, 3'd7, 8'hFF, 1'b0, 8'h00}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	action_t           action = ACT_INIT;
	logic [7:0]        data_byte = 8'h00;
	logic [2:0]        row = 3'd0;
	logic [7:0]        column = 8'h00;
	logic              cfg_write = 1'b0;
	logic              cfg_index = CFG_STROBE_HOLD;
	logic [HOLD_W-1:0] cfg_data = '0;
	logic              busy;
	logic              result_strobe;
	logic              reg_select;
	logic [3:0]        nibble;
	logic              enable;
	logic [HOLD_W-1:0] hold_us;
	logic              last;

	// Side info for the item on the command port
	logic              item_typed = 1'b0;
	logic [7:0]        item_sent = 8'h00;

	// Register copies, reset values 20 us and 50000 us
	logic [STROBE_W-1:0] strobe_hold_cur = 10'd20;
	logic [HOLD_W-1:0]   power_wait_cur = 17'd50000;

	pin_step_t pin_steps_q[$];
	int        fail_count = 0;
	int        cycle_count = 0;

	char_lcd_nibble_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.data_byte    (data_byte),
		.row          (row),
		.column       (column),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_strobe(result_strobe),
		.reg_select   (reg_select),
		.nibble       (nibble),
		.enable       (enable),
		.hold_us      (hold_us),
		.last         (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Set-DDRAM command for a row and a one-based column
	function automatic logic [7:0] cursor_command(logic [2:0] r, logic [7:0] c);
		logic [7:0] base;
		case (r)
			3'd1:    base = 8'h00;
			3'd2:    base = 8'h40;
			3'd3:    base = 8'h14;
			3'd4:    base = 8'h54;
			default: base = 8'h00;
		endcase
		return SET_DDRAM | (base + c - 8'd1);
	endfunction

	task automatic queue_step(logic rs, logic [3:0] nib, logic en, logic [HOLD_W-1:0] hold_v);
		pin_step_t s;
		s = '{rs, nib, en, hold_v, 1'b0};
		pin_steps_q.push_back(s);
	endtask

	// High nibble then low nibble, each as enable high then enable low
	task automatic queue_byte(logic rs, logic [7:0] b, int unsigned extra_us);
		queue_step(rs, b[7:4], 1'b1, HOLD_W'(strobe_hold_cur));
		queue_step(rs, b[7:4], 1'b0, HOLD_W'(strobe_hold_cur));
		queue_step(rs, b[3:0], 1'b1, HOLD_W'(strobe_hold_cur));
		queue_step(rs, b[3:0], 1'b0, HOLD_W'(strobe_hold_cur + extra_us));
	endtask

	task automatic predict_item(action_t a, logic [7:0] b, logic [2:0] r, logic [7:0] c,
			logic typed, logic [7:0] sent);
		pin_step_t tail;
		int        i;
		case (a)
			ACT_INIT: begin
				queue_step(1'b0, 4'h0, 1'b0, power_wait_cur);
				for (i = 0; i < 9; i++)
					queue_byte(1'b0, POWER_ON_CMDS[i], POWER_ON_MS[i] * 1000);
			end
			ACT_CMD:  queue_byte(1'b0, typed ? sent : b, 0);
			ACT_DATA: queue_byte(1'b1, typed ? sent : b, 0);
			default:  queue_byte(1'b0, typed ? sent : cursor_command(r, c), 0);
		endcase
		tail = pin_steps_q.pop_back();
		tail.last = 1'b1;
		pin_steps_q.push_back(tail);
	endtask

	function automatic void check_pin(string what, logic [HOLD_W-1:0] want,
			logic [HOLD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// Compare each result with the oldest expected step, then predict on accept
	always @(posedge clk) begin : scoreboard
		pin_step_t want;
		if (arst_n) begin
			if (result_strobe === 1'b1) begin
				if (pin_steps_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got rs=%0d nib=%0h en=%0d",
						$time, reg_select, nibble, enable);
					fail_count++;
				end else begin
					want = pin_steps_q.pop_front();
					check_pin("reg_select", HOLD_W'(want.rs), HOLD_W'(reg_select));
					check_pin("nibble", HOLD_W'(want.nib), HOLD_W'(nibble));
					check_pin("enable", HOLD_W'(want.en), HOLD_W'(enable));
					check_pin("hold_us", want.hold, hold_us);
					check_pin("last", HOLD_W'(want.last), HOLD_W'(last));
				end
			end
			if (start && busy === 1'b0)
				predict_item(action, data_byte, row, column, item_typed, item_sent);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("char_lcd_nibble_writer regression: fail");
			$finish;
		end
	end

	// Random pause before an item; junk on the fields while start is low
	task automatic idle_gap(bit burst);
		int gap;
		int r;
		gap = 0;
		r = $urandom_range(0, 99);
		if (!burst) begin
			if (r >= 90)
				gap = $urandom_range(8, 40);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			action <= action_t'($urandom_range(0, 3));
			data_byte <= 8'($urandom_range(0, 255));
			row <= 3'($urandom_range(0, 7));
			column <= 8'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_item(action_t a, logic [7:0] b, logic [2:0] r, logic [7:0] c,
			logic typed, logic [7:0] sent);
		start <= 1'b1;
		action <= a;
		data_byte <= b;
		row <= r;
		column <= c;
		item_typed <= typed;
		item_sent <= sent;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Wait until the block is idle and every expected step has come
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pin_steps_q.size() != 0 || busy !== 1'b0);
	endtask

	task automatic write_reg(logic idx, logic [HOLD_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_STROBE_HOLD)
			strobe_hold_cur = val[STROBE_W-1:0];
		else
			power_wait_cur = val;
	endtask

	initial begin : stimulus
		lcd_vec_t   v;
		int         p;
		int         n;
		int         r;
		bit         burst;
		action_t    a;
		logic [7:0] col;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset settings, back to back first, then with gaps
		for (n = 0; n < DIRECTED_COUNT; n++) begin
			v = DIRECTED[n];
			idle_gap(n < 10);
			issue_item(v.act, v.dbyte, v.row_v, v.col_v, v.typed, v.sent);
		end

		// Random items under a series of register settings
		for (p = 1; p <= PHASES; p++) begin
			drain();
			case (p)
				1: begin
					write_reg(CFG_STROBE_HOLD, 17'd1);
					write_reg(CFG_POWER_WAIT, 17'd0);
				end
				2: begin
					write_reg(CFG_STROBE_HOLD, 17'd1000);
					write_reg(CFG_POWER_WAIT, 17'd100000);
				end
				3: begin
					write_reg(CFG_STROBE_HOLD, 17'h003FF);
					write_reg(CFG_POWER_WAIT, 17'h1FFFF);
				end
				// upper data bits fall outside the strobe register
				4: write_reg(CFG_STROBE_HOLD, 17'h1FC05);
				5: begin
					write_reg(CFG_STROBE_HOLD, 17'd0);
					write_reg(CFG_POWER_WAIT, HOLD_W'($urandom_range(0, 100000)));
				end
				default: begin
					write_reg(CFG_STROBE_HOLD, HOLD_W'($urandom_range(1, 1000)));
					write_reg(CFG_POWER_WAIT, HOLD_W'($urandom_range(0, 131071)));
				end
			endcase
			cfg_write <= 1'b0;
			burst = ($urandom_range(0, 3) == 0);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					a = ACT_INIT;
				else if (r < 38)
					a = ACT_CMD;
				else if (r < 68)
					a = ACT_DATA;
				else
					a = ACT_CURSOR;
				case ($urandom_range(0, 7))
					0:       col = 8'd0;
					1:       col = 8'd1;
					2:       col = 8'hFF;
					default: col = 8'($urandom_range(0, 255));
				endcase
				idle_gap(burst);
				issue_item(a, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), col,
					1'b0, 8'h00);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pin_steps_q.size() == 0) begin
			$display("char_lcd_nibble_writer regression: pass");
		end else begin
			if (pin_steps_q.size() != 0)
				$display("%0t: %0d expected steps never came", $time, pin_steps_q.size());
			$display("char_lcd_nibble_writer regression: fail");
		end
		$finish;
	end

endmodule
